[hw/rtl/ofel_pkg.sv]
// shared types, opcodes and abort code table for the fault event log
`default_nettype none
package ofel_pkg;

  localparam int LOG_DEPTH_DEF = 16;

  localparam int OPCODE_W      = 2;
  localparam int TIME_W        = 32;
  localparam int CODE_W        = 32;
  localparam int PARAM_W       = 16;
  localparam int MODE_W        = 8;
  localparam int READ_INDEX_W  = 4;
  localparam int CLASS_W       = 5;
  localparam int ENTRY_COUNT_W = 5;

  localparam logic [OPCODE_W-1:0] OP_LOG_FAULT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOG_MODE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ      = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_CLEAR     = 2'd3;

  localparam int NUM_KNOWN_CODES = 17;
  localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 5'd17;

  localparam logic [CODE_W-1:0] KNOWN_CODES [NUM_KNOWN_CODES] = '{
    32'h0609_0030, 32'h0609_0011, 32'h0601_0000, 32'h0601_0001, 32'h0601_0002,
    32'h0800_0020, 32'h0800_0021, 32'h0800_0022, 32'h0504_0000, 32'h0503_0000,
    32'h0602_0000, 32'h0604_0041, 32'h0604_0042, 32'h0604_0043, 32'h0604_0047,
    32'h0606_0000, 32'h0607_0010
  };

  // one stored log entry
  typedef struct packed {
    logic [TIME_W-1:0]  time_ms;
    logic [CODE_W-1:0]  abort_code;
    logic [PARAM_W-1:0] param_id;
    logic [MODE_W-1:0]  mode;
    logic               is_fault;
  } entry_t;

  // access decision for one accepted item
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic is_read;
    logic miss;
  } access_t;

  // position of the code in the known table, unknown when absent
  function automatic logic [CLASS_W-1:0] classify(input logic [CODE_W-1:0] code);
    logic [CLASS_W-1:0] cls;
    cls = CLASS_UNKNOWN;
    for (int k = NUM_KNOWN_CODES - 1; k >= 0; k--) begin
      if (code == KNOWN_CODES[k]) begin
        cls = CLASS_W'(k);
      end
    end
    return cls;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/ofel_if.sv]
// valid/ready channels for commands and results of the fault event log
`default_nettype none
interface ofel_cmd_if;
  logic                                  valid;
  logic                                  ready;
  logic [ofel_pkg::OPCODE_W-1:0]         opcode;
  logic [ofel_pkg::TIME_W-1:0]           time_ms;
  logic [ofel_pkg::CODE_W-1:0]           abort_code;
  logic [ofel_pkg::PARAM_W-1:0]          param_id;
  logic [ofel_pkg::MODE_W-1:0]           mode_in;
  logic [ofel_pkg::READ_INDEX_W-1:0]     read_index;

  modport source (output valid, opcode, time_ms, abort_code, param_id, mode_in,
                  read_index, input ready);
  modport sink (input valid, opcode, time_ms, abort_code, param_id, mode_in,
                read_index, output ready);
endinterface

interface ofel_res_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  status;
  logic [ofel_pkg::TIME_W-1:0]           out_time_ms;
  logic [ofel_pkg::CODE_W-1:0]           out_abort_code;
  logic [ofel_pkg::PARAM_W-1:0]          out_param_id;
  logic [ofel_pkg::MODE_W-1:0]           out_mode;
  logic                                  out_is_fault;
  logic [ofel_pkg::CLASS_W-1:0]          code_class;
  logic [ofel_pkg::ENTRY_COUNT_W-1:0]    entry_count;

  modport source (output valid, status, out_time_ms, out_abort_code, out_param_id,
                  out_mode, out_is_fault, code_class, entry_count, input ready);
  modport sink (input valid, status, out_time_ms, out_abort_code, out_param_id,
                out_mode, out_is_fault, code_class, entry_count, output ready);
endinterface
`default_nettype wire

[hw/rtl/ofel_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module ofel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ofel_ptr.sv]
// fill count, oldest pointer and slot selection for each accepted item
`default_nettype none
module ofel_ptr #(
  parameter int LOG_DEPTH = ofel_pkg::LOG_DEPTH_DEF,
  localparam int AW = $clog2(LOG_DEPTH),
  localparam int CW = $clog2(LOG_DEPTH + 1)
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  accept,
  input  wire logic [ofel_pkg::OPCODE_W-1:0]         opcode,
  input  wire logic [ofel_pkg::READ_INDEX_W-1:0]     read_index,
  output ofel_pkg::access_t                          acc,
  output logic      [AW-1:0]                         slot,
  output logic      [CW-1:0]                         count
);

  localparam int IW   = ofel_pkg::READ_INDEX_W;
  localparam int CMPW = (CW > IW) ? CW : IW;

  logic [CW-1:0]   fill;
  logic [CW-1:0]   fill_next;
  logic [AW-1:0]   oldest;
  logic [AW-1:0]   oldest_next;
  logic            full;
  logic [CMPW-1:0] idx_ext;
  logic [CMPW-1:0] fill_ext;
  logic [CMPW-1:0] pos_wide;
  logic [AW:0]     sum;
  logic [AW-1:0]   rd_slot;

  assign full     = (fill == CW'(LOG_DEPTH));
  assign idx_ext  = CMPW'(read_index);
  assign fill_ext = CMPW'(fill);
  // distance from the oldest entry, only meaningful on a hit
  assign pos_wide = fill_ext - CMPW'(1) - idx_ext;
  assign sum      = {1'b0, oldest} + {1'b0, pos_wide[AW-1:0]};
  assign rd_slot  = (sum >= (AW+1)'(LOG_DEPTH)) ? AW'(sum - (AW+1)'(LOG_DEPTH))
                                                : sum[AW-1:0];

  always_comb begin
    acc         = '0;
    slot        = rd_slot;
    fill_next   = fill;
    oldest_next = oldest;
    unique case (opcode)
      ofel_pkg::OP_LOG_FAULT, ofel_pkg::OP_LOG_MODE: begin
        acc.wr_en = accept;
        if (full) begin
          slot        = oldest;
          oldest_next = (oldest == AW'(LOG_DEPTH - 1)) ? '0 : oldest + AW'(1);
        end else begin
          slot      = fill[AW-1:0];
          fill_next = fill + CW'(1);
        end
      end
      ofel_pkg::OP_READ: begin
        acc.is_read = 1'b1;
        acc.miss    = (idx_ext >= fill_ext);
        acc.rd_en   = accept && !acc.miss;
      end
      ofel_pkg::OP_CLEAR: begin
        fill_next   = '0;
        oldest_next = '0;
      end
      default: begin
        fill_next = fill;
      end
    endcase
  end

  assign count = fill_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      oldest <= '0;
    end else if (accept) begin
      fill   <= fill_next;
      oldest <= oldest_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/overwriting_fault_event_log.sv]
// top level of the overwriting fault and mode-change event log
// usage:
//   cmd carries one item per handshake: opcode (log fault, log mode change,
//   read entry, clear), timestamp, abort code, parameter id, mode and a read
//   index counted back from the newest entry
//   res returns exactly one item per command: status, the fields of the entry
//   read, its abort code class and the entry count after the command
// timing:
//   the log ram read happens at the accepting edge; the read stage then moves
//   on into the result register, which classifies the code, once that
//   register is empty or being taken by res.ready
//   throughput is one item per cycle while res.ready stays high
// reset:
//   rst (synchronous) empties the log and drops both pipeline stages; the
//   ram contents are left as they are and are never read before written
// stalls:
//   when res.ready is low the result register and the read stage hold, and
//   cmd.ready falls once both are full; no item is dropped
`default_nettype none
module overwriting_fault_event_log #(
  parameter int LOG_DEPTH = ofel_pkg::LOG_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  ofel_cmd_if.sink   cmd,
  ofel_res_if.source res
);

  localparam int AW = $clog2(LOG_DEPTH);
  localparam int CW = $clog2(LOG_DEPTH + 1);
  localparam int EW = $bits(ofel_pkg::entry_t);

  // handshake and pointer logic
  logic              accept;
  ofel_pkg::access_t acc;
  logic [AW-1:0]     slot;
  logic [CW-1:0]     count;
  ofel_pkg::entry_t  wr_entry;
  logic [EW-1:0]     rd_bits;
  ofel_pkg::entry_t  rd_entry;

  // read stage: ram data lands here alongside the control bits
  logic                                s1_valid;
  logic                                s1_is_read;
  logic                                s1_miss;
  logic [ofel_pkg::ENTRY_COUNT_W-1:0]  s1_count;
  logic                                s1_move;
  logic                                hit;

  assign s1_move   = s1_valid && (!res.valid || res.ready);
  assign cmd.ready = !s1_valid || s1_move;
  assign accept    = cmd.valid && cmd.ready;

  ofel_ptr #(.LOG_DEPTH(LOG_DEPTH)) u_ptr (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .opcode     (cmd.opcode),
    .read_index (cmd.read_index),
    .acc        (acc),
    .slot       (slot),
    .count      (count)
  );

  // mode-change entries store zero code and id with the fault flag clear
  always_comb begin
    wr_entry.time_ms = cmd.time_ms;
    wr_entry.mode    = cmd.mode_in;
    if (cmd.opcode == ofel_pkg::OP_LOG_FAULT) begin
      wr_entry.abort_code = cmd.abort_code;
      wr_entry.param_id   = cmd.param_id;
      wr_entry.is_fault   = 1'b1;
    end else begin
      wr_entry.abort_code = '0;
      wr_entry.param_id   = '0;
      wr_entry.is_fault   = 1'b0;
    end
  end

  ofel_ram #(.WIDTH(EW), .DEPTH(LOG_DEPTH)) u_ram (
    .clk   (clk),
    .we    (acc.wr_en),
    .waddr (slot),
    .wdata (wr_entry),
    .re    (acc.rd_en),
    .raddr (slot),
    .rdata (rd_bits)
  );

  assign rd_entry = ofel_pkg::entry_t'(rd_bits);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_is_read <= acc.is_read;
      s1_miss    <= acc.miss;
      s1_count   <= ofel_pkg::ENTRY_COUNT_W'(count);
    end
  end

  // result register: zero fields unless a read hit
  assign hit = s1_is_read && !s1_miss;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_move) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res.status         <= s1_miss;
      res.entry_count    <= s1_count;
      res.out_time_ms    <= hit ? rd_entry.time_ms    : '0;
      res.out_abort_code <= hit ? rd_entry.abort_code : '0;
      res.out_param_id   <= hit ? rd_entry.param_id   : '0;
      res.out_mode       <= hit ? rd_entry.mode       : '0;
      res.out_is_fault   <= hit ? rd_entry.is_fault   : 1'b0;
      res.code_class     <= hit ? ofel_pkg::classify(rd_entry.abort_code) : '0;
    end
  end

  // a miss result never carries entry data
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status |-> res.out_time_ms == '0 && res.code_class == '0
                                && res.out_is_fault == 1'b0)
    else $error("miss result carries entry data");

  // the count after any item never exceeds the log depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    accept |-> count <= CW'(LOG_DEPTH))
    else $error("entry count beyond log depth");

  // a clear empties the log for its own result
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.opcode == ofel_pkg::OP_CLEAR |=> s1_valid && s1_count == '0)
    else $error("clear did not empty the log");

  // a stalled read stage keeps its item
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_count))
    else $error("read stage lost an item while stalled");

endmodule
`default_nettype wire

[dv/ofel_log_checker.sv]
// watches both channels of the event log, predicts every reply and compares it
module ofel_log_checker
  import ofel_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ofel_cmd_if        cmd,
  ofel_res_if        res,
  output int         fail_count,
  output int         awaited_count
);

  typedef struct packed {
    logic                     status;
    logic [TIME_W-1:0]        time_ms;
    logic [CODE_W-1:0]        abort_code;
    logic [PARAM_W-1:0]       param_id;
    logic [MODE_W-1:0]        mode;
    logic                     is_fault;
    logic [CLASS_W-1:0]       code_class;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } reply_t;

  entry_t log_copy [LOG_DEPTH_DEF];
  int     used_slots;
  int     oldest_pos;
  reply_t awaited_replies [$];

  initial begin
    fail_count    = 0;
    awaited_count = 0;
    used_slots    = 0;
    oldest_pos    = 0;
  end

  function automatic logic [CLASS_W-1:0] code_rank(input logic [CODE_W-1:0] code);
    logic [CLASS_W-1:0] rank;
    rank = CLASS_UNKNOWN;
    for (int k = 0; k < NUM_KNOWN_CODES; k++) begin
      if (rank == CLASS_UNKNOWN && code == KNOWN_CODES[k]) begin
        rank = CLASS_W'(k);
      end
    end
    return rank;
  endfunction

  // appends an entry; a full log overwrites the oldest slot and moves the oldest pointer on
  task automatic append_copy(input entry_t e);
    if (used_slots < LOG_DEPTH_DEF) begin
      log_copy[used_slots] = e;
      used_slots++;
    end else begin
      log_copy[oldest_pos] = e;
      oldest_pos = (oldest_pos + 1) % LOG_DEPTH_DEF;
    end
  endtask

  task automatic log_outcome(output reply_t r);
    entry_t e;
    int     slot;
    r = '0;
    e = '0;
    case (cmd.opcode)
      OP_LOG_FAULT: begin
        e.time_ms    = cmd.time_ms;
        e.abort_code = cmd.abort_code;
        e.param_id   = cmd.param_id;
        e.mode       = cmd.mode_in;
        e.is_fault   = 1'b1;
        append_copy(e);
      end
      OP_LOG_MODE: begin
        e.time_ms = cmd.time_ms;
        e.mode    = cmd.mode_in;
        append_copy(e);
      end
      OP_READ: begin
        if (int'(cmd.read_index) >= used_slots) begin
          r.status = 1'b1;
        end else begin
          slot = (oldest_pos + used_slots - 1 - int'(cmd.read_index)) % LOG_DEPTH_DEF;
          e = log_copy[slot];
          r.time_ms    = e.time_ms;
          r.abort_code = e.abort_code;
          r.param_id   = e.param_id;
          r.mode       = e.mode;
          r.is_fault   = e.is_fault;
          r.code_class = code_rank(e.abort_code);
        end
      end
      OP_CLEAR: begin
        used_slots = 0;
        oldest_pos = 0;
      end
      default: ;
    endcase
    r.entry_count = ENTRY_COUNT_W'(used_slots);
  endtask

  task automatic report(input string what);
    fail_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst) begin
      if (cmd.valid && cmd.ready) begin
        log_outcome(want);
        awaited_replies.push_back(want);
      end
      if (res.valid && res.ready) begin
        if (awaited_replies.size() == 0) begin
          report("reply with no command waiting");
        end else begin
          want = awaited_replies.pop_front();
          check_field("status", 32'(res.status), 32'(want.status));
          check_field("out_time_ms", res.out_time_ms, want.time_ms);
          check_field("out_abort_code", res.out_abort_code, want.abort_code);
          check_field("out_param_id", 32'(res.out_param_id), 32'(want.param_id));
          check_field("out_mode", 32'(res.out_mode), 32'(want.mode));
          check_field("out_is_fault", 32'(res.out_is_fault), 32'(want.is_fault));
          check_field("code_class", 32'(res.code_class), 32'(want.code_class));
          check_field("entry_count", 32'(res.entry_count), 32'(want.entry_count));
        end
      end
      awaited_count = awaited_replies.size();
    end
  end

endmodule

[dv/tb.sv]
// top of the event log testbench: clock, reset, command stimulus, reply stalls, verdict
module tb;
  import ofel_pkg::*;

  // receiver stall patterns, one picked per stretch
  typedef enum int {RX_FREE, RX_LIGHT, RX_HALF, RX_HEAVY, RX_HOLD} stall_pattern_t;

  localparam int RANDOM_ITEMS = 1200;

  logic clk;
  logic rst;
  int   fail_count;
  int   awaited_count;
  int   burst_left;
  int   shadow_fill;   // rough entry count, only used to steer read indexes

  ofel_cmd_if cmd_ch ();
  ofel_res_if res_ch ();

  overwriting_fault_event_log DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  ofel_log_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd_ch),
    .res           (res_ch),
    .fail_count    (fail_count),
    .awaited_count (awaited_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // hard stop well past the slowest legal run
  initial begin
    #(400000 * 12);
    $display("CHECKS FAILED");
    $finish;
  end

  // every input known from time zero
  initial begin
    rst               = 1'b1;
    cmd_ch.valid      = 1'b0;
    cmd_ch.opcode     = OP_READ;
    cmd_ch.time_ms    = '0;
    cmd_ch.abort_code = '0;
    cmd_ch.param_id   = '0;
    cmd_ch.mode_in    = '0;
    cmd_ch.read_index = '0;
    res_ch.ready      = 1'b0;
  end

  // offer one item; the sender works in bursts with idle gaps between them
  task automatic issue(input logic [OPCODE_W-1:0] op, input logic [TIME_W-1:0] t,
                       input logic [CODE_W-1:0] code, input logic [PARAM_W-1:0] pid,
                       input logic [MODE_W-1:0] mode, input logic [READ_INDEX_W-1:0] idx);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      // sometimes no gap at all, so long gapless stretches occur too
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        cmd_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    cmd_ch.opcode     = op;
    cmd_ch.time_ms    = t;
    cmd_ch.abort_code = code;
    cmd_ch.param_id   = pid;
    cmd_ch.mode_in    = mode;
    cmd_ch.read_index = idx;
    cmd_ch.valid      = 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    // track the count the log should hold, for read index steering
    if (op == OP_LOG_FAULT || op == OP_LOG_MODE) begin
      if (shadow_fill < LOG_DEPTH_DEF) shadow_fill++;
    end else if (op == OP_CLEAR) begin
      shadow_fill = 0;
    end
  endtask

  // table codes and their one-bit neighbours, the extremes and random codes
  function automatic logic [CODE_W-1:0] pick_code();
    logic [CODE_W-1:0] code;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: code = KNOWN_CODES[$urandom_range(0, NUM_KNOWN_CODES - 1)];
      4: code = KNOWN_CODES[$urandom_range(0, NUM_KNOWN_CODES - 1)] ^ (32'd1 << $urandom_range(0, 31));
      5: code = '0;
      6: code = '1;
      default: code = $urandom;
    endcase
    return code;
  endfunction

  task automatic random_item();
    logic [OPCODE_W-1:0]     op;
    logic [READ_INDEX_W-1:0] idx;
    int                      pick;
    pick = $urandom_range(0, 199);
    // mostly logs and reads; clears are rare so the log fills and wraps often
    if (pick < 70)       op = OP_LOG_FAULT;
    else if (pick < 100) op = OP_LOG_MODE;
    else if (pick < 197) op = OP_READ;
    else                 op = OP_CLEAR;
    // reads mostly inside the filled range, the rest anywhere
    if (shadow_fill > 0 && $urandom_range(0, 3) != 0) begin
      idx = READ_INDEX_W'($urandom_range(0, shadow_fill - 1));
    end else begin
      idx = READ_INDEX_W'($urandom_range(0, 15));
    end
    issue(op, $urandom, pick_code(), PARAM_W'($urandom_range(0, 65535)),
          MODE_W'($urandom_range(0, 255)), idx);
  endtask

  // receiver: random stall patterns per stretch, the fourth one a long hold-off
  initial begin
    stall_pattern_t pattern;
    int             span;
    while (rst) @(negedge clk);
    for (int n = 0; ; n++) begin
      if (n == 3) begin
        pattern = RX_HOLD;
      end else if ($urandom_range(0, 15) == 0) begin
        pattern = RX_HOLD;
      end else begin
        pattern = stall_pattern_t'($urandom_range(0, 3));
      end
      span = (pattern == RX_HOLD) ? $urandom_range(60, 100) : $urandom_range(20, 120);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        case (pattern)
          RX_FREE:  res_ch.ready = 1'b1;
          RX_LIGHT: res_ch.ready = ($urandom_range(0, 3) != 0);
          RX_HALF:  res_ch.ready = 1'($urandom_range(0, 1));
          RX_HEAVY: res_ch.ready = ($urandom_range(0, 9) == 0);
          default:  res_ch.ready = 1'b0;
        endcase
      end
    end
  end

  // stimulus and verdict
  initial begin
    burst_left  = 0;
    shadow_fill = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reads of an empty log, clear of an empty log
    issue(OP_READ, 32'd0, 32'd0, 16'd0, 8'd0, 4'd0);
    issue(OP_READ, 32'hffff_ffff, '1, '1, '1, 4'd15);
    issue(OP_CLEAR, '1, '1, '1, '1, '1);
    // field extremes, then table codes at both ends
    issue(OP_LOG_FAULT, '1, '1, '1, '1, '1);
    issue(OP_LOG_FAULT, '0, '0, '0, '0, '0);
    issue(OP_LOG_FAULT, 32'h0000_0100, KNOWN_CODES[0], 16'h1234, 8'h01, 4'd0);
    issue(OP_LOG_FAULT, 32'h8000_0000, KNOWN_CODES[NUM_KNOWN_CODES - 1], 16'h8000,
          8'h80, 4'd0);
    // mode change ignores code and id given with it
    issue(OP_LOG_MODE, 32'h1234_5678, 32'h0609_0030, 16'hbeef, 8'hff, 4'd3);
    issue(OP_READ, '0, '0, '0, '0, 4'd0);    // mode-change entry, unknown class
    issue(OP_READ, '0, '0, '0, '0, 4'd4);    // oldest, all-ones fault
    issue(OP_READ, '0, '0, '0, '0, 4'd3);    // all-zero fault
    issue(OP_READ, '0, '0, '0, '0, 4'd2);
    issue(OP_READ, '0, '0, '0, '0, 4'd1);
    issue(OP_READ, '0, '0, '0, '0, 4'd5);    // just past the filled entries
    issue(OP_READ, '0, '0, '0, '0, 4'd15);
    issue(OP_CLEAR, '0, '0, '0, '0, '0);
    issue(OP_READ, '0, '0, '0, '0, 4'd0);    // cleared log reads as empty
    issue(OP_LOG_MODE, 32'h0000_0001, '0, '0, 8'h00, 4'd0);
    issue(OP_READ, '0, '0, '0, '0, 4'd0);
    issue(OP_READ, '0, '0, '0, '0, 4'd1);

    // random part, long enough to fill and wrap the log many times
    repeat (RANDOM_ITEMS) random_item();

    @(negedge clk);
    cmd_ch.valid = 1'b0;
    while (awaited_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ofel_pkg.sv
hw/rtl/ofel_if.sv
hw/rtl/ofel_ram.sv
hw/rtl/ofel_ptr.sv
hw/rtl/overwriting_fault_event_log.sv
dv/ofel_log_checker.sv
dv/tb.sv
